@@ rtl/yuvt_pkg.sv @@
package yuvt_pkg;

  localparam int unsigned SampleW   = 8;
  localparam int unsigned GainW     = 12;
  localparam int unsigned BrightW   = 9;
  localparam int unsigned TrigW     = 14;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 14;
  localparam int unsigned Latency   = 4;

  localparam logic [CfgIdxW-1:0] CfgContrast   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSaturation = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBrightness = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHueCos     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHueSin     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCoring     = 3'd5;

  localparam logic [GainW-1:0]   ContrastRst   = 12'd512;
  localparam logic [GainW-1:0]   SaturationRst = 12'd512;
  localparam logic [BrightW-1:0] BrightnessRst = 9'd0;
  localparam logic [TrigW-1:0]   HueCosRst     = 14'd4096;
  localparam logic [TrigW-1:0]   HueSinRst     = 14'd0;
  localparam logic               CoringRst     = 1'b1;

  localparam logic signed [15:0] LumaLoVideo   = 16'sd16;
  localparam logic signed [15:0] LumaHiVideo   = 16'sd235;
  localparam logic signed [15:0] ChromaHiVideo = 16'sd240;
  localparam logic signed [15:0] FullLo        = 16'sd0;
  localparam logic signed [15:0] FullHi        = 16'sd255;

  function automatic logic [SampleW-1:0] clamp8(input logic signed [15:0] x,
                                                input logic signed [15:0] lo,
                                                input logic signed [15:0] hi);
    logic signed [15:0] r;
    begin
      r = x;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      clamp8 = r[SampleW-1:0];
    end
  endfunction

endpackage

@@ rtl/yuv_tweak_hue_sat_bright_cont.sv @@
// Adjusts one 4:2:2 group (two luma samples and a U/V pair) per clock: luma
// contrast, brightness and clamp; chroma hue rotation, saturation and clamp.
// A group is taken whenever start_i is high; busy_o stays low, so a new group
// may follow in every cycle. The four register stages (products, rotate and
// luma clamp, saturation product, chroma clamp) carry a valid flag along
// (v1_q, v2_q, v3_q, done_q) that raises done_o with the result. It is
// shown for one cycle only: the receiver cannot stall it and must take it then.
// Configuration writes take effect at once and should be made while no group
// is in flight.
module yuv_tweak_hue_sat_bright_cont (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  output logic                             done_o,
  input  logic                             cfg_we_i,
  input  logic [yuvt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [yuvt_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic [yuvt_pkg::SampleW-1:0]     luma_first_i,
  input  logic [yuvt_pkg::SampleW-1:0]     chroma_u_i,
  input  logic [yuvt_pkg::SampleW-1:0]     luma_second_i,
  input  logic [yuvt_pkg::SampleW-1:0]     chroma_v_i,
  output logic [yuvt_pkg::SampleW-1:0]     luma_first_out_o,
  output logic [yuvt_pkg::SampleW-1:0]     chroma_u_out_o,
  output logic [yuvt_pkg::SampleW-1:0]     luma_second_out_o,
  output logic [yuvt_pkg::SampleW-1:0]     chroma_v_out_o
);

  logic [yuvt_pkg::GainW-1:0]   contrast_q, saturation_q;
  logic [yuvt_pkg::BrightW-1:0] brightness_q;
  logic [yuvt_pkg::TrigW-1:0]   hue_cos_q, hue_sin_q;
  logic                         coring_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q   <= yuvt_pkg::ContrastRst;
      saturation_q <= yuvt_pkg::SaturationRst;
      brightness_q <= yuvt_pkg::BrightnessRst;
      hue_cos_q    <= yuvt_pkg::HueCosRst;
      hue_sin_q    <= yuvt_pkg::HueSinRst;
      coring_q     <= yuvt_pkg::CoringRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        yuvt_pkg::CfgContrast:   contrast_q   <= cfg_wdata_i[yuvt_pkg::GainW-1:0];
        yuvt_pkg::CfgSaturation: saturation_q <= cfg_wdata_i[yuvt_pkg::GainW-1:0];
        yuvt_pkg::CfgBrightness: brightness_q <= cfg_wdata_i[yuvt_pkg::BrightW-1:0];
        yuvt_pkg::CfgHueCos:     hue_cos_q    <= cfg_wdata_i[yuvt_pkg::TrigW-1:0];
        yuvt_pkg::CfgHueSin:     hue_sin_q    <= cfg_wdata_i[yuvt_pkg::TrigW-1:0];
        yuvt_pkg::CfgCoring:     coring_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // stage 1: products
  logic signed [7:0]  u_c, v_c;
  logic signed [8:0]  y0_c, y1_c;
  logic signed [12:0] con_c;
  logic signed [21:0] uc_d, vs_d, vc_d, us_d, lp0_d, lp1_d;
  logic signed [21:0] uc_q, vs_q, vc_q, us_q, lp0_q, lp1_q;
  logic               v1_q;

  assign u_c   = $signed({~chroma_u_i[7], chroma_u_i[6:0]});
  assign v_c   = $signed({~chroma_v_i[7], chroma_v_i[6:0]});
  assign y0_c  = $signed({1'b0, luma_first_i}) - 9'sd16;
  assign y1_c  = $signed({1'b0, luma_second_i}) - 9'sd16;
  assign con_c = $signed({1'b0, contrast_q});
  assign uc_d  = u_c * $signed(hue_cos_q);
  assign vs_d  = v_c * $signed(hue_sin_q);
  assign vc_d  = v_c * $signed(hue_cos_q);
  assign us_d  = u_c * $signed(hue_sin_q);
  assign lp0_d = y0_c * con_c;
  assign lp1_d = y1_c * con_c;

  always_ff @(posedge clk_i) begin
    uc_q  <= uc_d;
    vs_q  <= vs_d;
    vc_q  <= vc_d;
    us_q  <= us_d;
    lp0_q <= lp0_d;
    lp1_q <= lp1_d;
  end

  // stage 2: rotate, luma offset and clamp
  logic signed [22:0] usum_c, vsum_c, ush_c, vsh_c;
  logic signed [10:0] ur_d, vr_d, ur_q, vr_q;
  logic signed [21:0] ls0_c, ls1_c;
  logic signed [15:0] la0_c, la1_c, bri_c;
  logic signed [15:0] llo_c, lhi_c;
  logic [7:0]         l0_d, l1_d, l0_q, l1_q, l0b_q, l1b_q;
  logic               v2_q;

  assign usum_c = 23'(uc_q) + 23'(vs_q);
  assign vsum_c = 23'(vc_q) - 23'(us_q);
  assign ush_c  = usum_c >>> 12;
  assign vsh_c  = vsum_c >>> 12;
  assign ur_d   = ush_c[10:0];
  assign vr_d   = vsh_c[10:0];
  assign ls0_c  = lp0_q >>> 9;
  assign ls1_c  = lp1_q >>> 9;
  assign bri_c  = 16'($signed(brightness_q));
  assign la0_c  = ls0_c[15:0] + bri_c + 16'sd16;
  assign la1_c  = ls1_c[15:0] + bri_c + 16'sd16;
  assign llo_c  = coring_q ? yuvt_pkg::LumaLoVideo : yuvt_pkg::FullLo;
  assign lhi_c  = coring_q ? yuvt_pkg::LumaHiVideo : yuvt_pkg::FullHi;
  assign l0_d   = yuvt_pkg::clamp8(la0_c, llo_c, lhi_c);
  assign l1_d   = yuvt_pkg::clamp8(la1_c, llo_c, lhi_c);

  always_ff @(posedge clk_i) begin
    ur_q <= ur_d;
    vr_q <= vr_d;
    l0_q <= l0_d;
    l1_q <= l1_d;
  end

  // stage 3: saturation products
  logic signed [12:0] sat_c;
  logic signed [23:0] up_d, vp_d, up_q, vp_q;
  logic               v3_q;

  assign sat_c = $signed({1'b0, saturation_q});
  assign up_d  = ur_q * sat_c;
  assign vp_d  = vr_q * sat_c;

  always_ff @(posedge clk_i) begin
    up_q  <= up_d;
    vp_q  <= vp_d;
    l0b_q <= l0_q;
    l1b_q <= l1_q;
  end

  // stage 4: chroma offset, clamp, output register
  logic signed [23:0] ush2_c, vsh2_c;
  logic signed [15:0] uo_c, vo_c, clo_c, chi_c;
  logic [7:0]         uout_q, vout_q, l0out_q, l1out_q;
  logic               done_q;

  assign ush2_c = up_q >>> 9;
  assign vsh2_c = vp_q >>> 9;
  assign uo_c   = ush2_c[15:0] + 16'sd128;
  assign vo_c   = vsh2_c[15:0] + 16'sd128;
  assign clo_c  = coring_q ? yuvt_pkg::LumaLoVideo : yuvt_pkg::FullLo;
  assign chi_c  = coring_q ? yuvt_pkg::ChromaHiVideo : yuvt_pkg::FullHi;

  always_ff @(posedge clk_i) begin
    uout_q  <= yuvt_pkg::clamp8(uo_c, clo_c, chi_c);
    vout_q  <= yuvt_pkg::clamp8(vo_c, clo_c, chi_c);
    l0out_q <= l0b_q;
    l1out_q <= l1b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  assign busy_o            = 1'b0;
  assign done_o            = done_q;
  assign luma_first_out_o  = l0out_q;
  assign chroma_u_out_o    = uout_q;
  assign luma_second_out_o = l1out_q;
  assign chroma_v_out_o    = vout_q;

endmodule

@@ rtl/yuvt_checker.sv @@
module yuvt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o raised");

  a_done_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result word without an accepted word");

  a_word_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) ##1 rst_ni ##1 rst_ni ##1 rst_ni |=> done_o)
    else $error("accepted word lost");

endmodule

bind yuv_tweak_hue_sat_bright_cont yuvt_checker u_yuvt_checker (.*);

@@ dv/yuvt_result_checker.sv @@
`timescale 1ns / 100ps

module yuvt_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          done_i,
  input  logic                          cfg_we_i,
  input  logic [yuvt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [yuvt_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [yuvt_pkg::SampleW-1:0]  luma_first_i,
  input  logic [yuvt_pkg::SampleW-1:0]  chroma_u_i,
  input  logic [yuvt_pkg::SampleW-1:0]  luma_second_i,
  input  logic [yuvt_pkg::SampleW-1:0]  chroma_v_i,
  input  logic [yuvt_pkg::SampleW-1:0]  luma_first_out_i,
  input  logic [yuvt_pkg::SampleW-1:0]  chroma_u_out_i,
  input  logic [yuvt_pkg::SampleW-1:0]  luma_second_out_i,
  input  logic [yuvt_pkg::SampleW-1:0]  chroma_v_out_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import yuvt_pkg::*;

  typedef struct packed {
    logic [SampleW-1:0] luma_first;
    logic [SampleW-1:0] chroma_u;
    logic [SampleW-1:0] luma_second;
    logic [SampleW-1:0] chroma_v;
  } yuv_group_t;

  logic [GainW-1:0]          contrast_q;
  logic [GainW-1:0]          saturation_q;
  logic signed [BrightW-1:0] brightness_q;
  logic signed [TrigW-1:0]   hue_cos_q;
  logic signed [TrigW-1:0]   hue_sin_q;
  logic                      coring_q;

  yuv_group_t expected_groups[$];
  int         fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [SampleW-1:0] clamp_sample(input longint x, input longint lo,
                                                      input longint hi);
    longint r;
    r = x;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r[SampleW-1:0];
  endfunction

  function automatic logic [SampleW-1:0] luma_adjust(input logic [SampleW-1:0] y);
    longint t;
    longint gain;
    longint bri;
    longint lo;
    longint hi;
    t    = y;
    t    = t - 16;
    gain = contrast_q;
    bri  = brightness_q;
    t    = ((gain * t) >>> 9) + bri + 16;
    lo   = coring_q ? LumaLoVideo : FullLo;
    hi   = coring_q ? LumaHiVideo : FullHi;
    return clamp_sample(t, lo, hi);
  endfunction

  function automatic yuv_group_t adjust_group(input yuv_group_t g);
    yuv_group_t r;
    longint c;
    longint s;
    longint u;
    longint v;
    longint ur;
    longint vr;
    longint sat;
    longint lo;
    longint hi;
    c   = hue_cos_q;
    s   = hue_sin_q;
    u   = g.chroma_u;
    u   = u - 128;
    v   = g.chroma_v;
    v   = v - 128;
    ur  = (u * c + v * s) >>> 12;
    vr  = (v * c - u * s) >>> 12;
    sat = saturation_q;
    lo  = coring_q ? LumaLoVideo : FullLo;
    hi  = coring_q ? ChromaHiVideo : FullHi;
    r.luma_first  = luma_adjust(g.luma_first);
    r.chroma_u    = clamp_sample(((ur * sat) >>> 9) + 128, lo, hi);
    r.luma_second = luma_adjust(g.luma_second);
    r.chroma_v    = clamp_sample(((vr * sat) >>> 9) + 128, lo, hi);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [SampleW-1:0] want,
                               input logic [SampleW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    yuv_group_t want;
    yuv_group_t got;
    if (!rst_ni) begin
      contrast_q   <= ContrastRst;
      saturation_q <= SaturationRst;
      brightness_q <= BrightnessRst;
      hue_cos_q    <= HueCosRst;
      hue_sin_q    <= HueSinRst;
      coring_q     <= CoringRst;
      expected_groups.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgContrast:   contrast_q   <= cfg_wdata_i[GainW-1:0];
          CfgSaturation: saturation_q <= cfg_wdata_i[GainW-1:0];
          CfgBrightness: brightness_q <= cfg_wdata_i[BrightW-1:0];
          CfgHueCos:     hue_cos_q    <= cfg_wdata_i[TrigW-1:0];
          CfgHueSin:     hue_sin_q    <= cfg_wdata_i[TrigW-1:0];
          CfgCoring:     coring_q     <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        expected_groups.push_back(adjust_group({luma_first_i, chroma_u_i,
                                                luma_second_i, chroma_v_i}));
      end
      if (done_i) begin
        got = {luma_first_out_i, chroma_u_out_i, luma_second_out_i, chroma_v_out_i};
        if (expected_groups.size() == 0) begin
          $display("%0t: word with nothing pending, expected none, actual %h", $time, got);
          fails++;
        end else begin
          want = expected_groups.pop_front();
          compare_field("luma_first_out", want.luma_first, got.luma_first);
          compare_field("chroma_u_out", want.chroma_u, got.chroma_u);
          compare_field("luma_second_out", want.luma_second, got.luma_second);
          compare_field("chroma_v_out", want.chroma_v, got.chroma_v);
        end
      end
      pending_o <= expected_groups.size();
    end
    fail_count_o <= fails;
  end

endmodule

@@ dv/yuv_tweak_hue_sat_bright_cont_tb.sv @@
`timescale 1ns / 100ps

module yuv_tweak_hue_sat_bright_cont_tb;
  import yuvt_pkg::*;

  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned RandomPhases   = 9;
  localparam int unsigned GroupsPerPhase = 50;

  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start_i       = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic [SampleW-1:0]  luma_first_i  = '0;
  logic [SampleW-1:0]  chroma_u_i    = '0;
  logic [SampleW-1:0]  luma_second_i = '0;
  logic [SampleW-1:0]  chroma_v_i    = '0;
  logic                busy_o;
  logic                done_o;
  logic [SampleW-1:0]  luma_first_out_o;
  logic [SampleW-1:0]  chroma_u_out_o;
  logic [SampleW-1:0]  luma_second_out_o;
  logic [SampleW-1:0]  chroma_v_out_o;

  int          fail_count;
  int          pending;
  int unsigned idle_pct     = 0;
  int unsigned quiet_cycles = 0;

  yuv_tweak_hue_sat_bright_cont dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .luma_first_i      (luma_first_i),
    .chroma_u_i        (chroma_u_i),
    .luma_second_i     (luma_second_i),
    .chroma_v_i        (chroma_v_i),
    .luma_first_out_o  (luma_first_out_o),
    .chroma_u_out_o    (chroma_u_out_o),
    .luma_second_out_o (luma_second_out_o),
    .chroma_v_out_o    (chroma_v_out_o)
  );

  yuvt_result_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .done_i            (done_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .luma_first_i      (luma_first_i),
    .chroma_u_i        (chroma_u_i),
    .luma_second_i     (luma_second_i),
    .chroma_v_i        (chroma_v_i),
    .luma_first_out_i  (luma_first_out_o),
    .chroma_u_out_i    (chroma_u_out_o),
    .luma_second_out_i (luma_second_out_o),
    .chroma_v_out_i    (chroma_v_out_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      3: return 8'd235;
      4: return 8'd240;
      5: return 8'd128;
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2: return 512;
      default: return int'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic int pick_trig();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 16383)) - 8192;
    return int'($urandom_range(0, 8192)) - 4096;
  endfunction

  task automatic send_group(input logic [SampleW-1:0] y0, input logic [SampleW-1:0] u,
                            input logic [SampleW-1:0] y1, input logic [SampleW-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i      <= 1'b0;
      luma_first_i <= SampleW'($urandom);
      chroma_v_i   <= SampleW'($urandom);
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    luma_first_i  <= y0;
    chroma_u_i    <= u;
    luma_second_i <= y1;
    chroma_v_i    <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value,
                           input int unsigned width);
    logic [CfgDataW-1:0] mask;
    mask        = CfgDataW'((1 << width) - 1);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= (CfgDataW'($urandom) & ~mask) | (CfgDataW'(value) & mask);
    @(posedge clk_i);
  endtask

  task automatic program_setting(input int ctr, input int sat, input int bri,
                                 input int hcos, input int hsin, input int cor);
    start_i <= 1'b0;
    @(posedge clk_i);
    // hold off until every word in flight has come back
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    write_reg(CfgUnusedLo, int'($urandom), CfgDataW);
    write_reg(CfgUnusedHi, int'($urandom), CfgDataW);
    write_reg(CfgContrast, ctr, GainW);
    write_reg(CfgSaturation, sat, GainW);
    write_reg(CfgBrightness, bri, BrightW);
    write_reg(CfgHueCos, hcos, TrigW);
    write_reg(CfgHueSin, hsin, TrigW);
    write_reg(CfgCoring, cor, 1);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_group(8'd0, 8'd0, 8'd0, 8'd0);
    send_group(8'd255, 8'd255, 8'd255, 8'd255);
    send_group(8'd16, 8'd128, 8'd235, 8'd128);
    send_group(8'd15, 8'd15, 8'd236, 8'd241);
    send_group(8'd235, 8'd240, 8'd16, 8'd16);
    send_group(8'd128, 8'd0, 8'd128, 8'd255);
    send_group(8'd1, 8'd254, 8'd254, 8'd1);

    program_setting(4095, 4095, 255, 8191, -8192, 0);
    send_group(8'd0, 8'd0, 8'd255, 8'd255);
    send_group(8'd16, 8'd129, 8'd17, 8'd127);
    send_group(8'd255, 8'd128, 8'd0, 8'd128);

    program_setting(0, 0, -256, -4096, 4096, 1);
    send_group(8'd0, 8'd255, 8'd255, 8'd0);
    send_group(8'd128, 8'd128, 8'd128, 8'd128);

    program_setting(512, 1024, -255, 0, 4096, 0);
    send_group(8'd255, 8'd0, 8'd0, 8'd255);
    send_group(8'd100, 8'd200, 8'd50, 8'd60);

    program_setting(2048, 512, 100, -8192, 8191, 1);
    send_group(8'd0, 8'd0, 8'd255, 8'd255);
    send_group(8'd200, 8'd255, 8'd30, 8'd0);

    for (phase = 0; phase < RandomPhases; phase++) begin
      program_setting(pick_gain(), pick_gain(), int'($urandom_range(0, 511)) - 256,
                      pick_trig(), pick_trig(), int'($urandom_range(0, 1)));
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 80;
        default: idle_pct = 38;
      endcase
      for (n = 0; n < GroupsPerPhase; n++) begin
        send_group(pick_sample(), pick_sample(), pick_sample(), pick_sample());
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
